### hw/rtl/sliding_window_stats_top_macros.svh
// Assertion macros for the sliding window statistics checker
`ifndef SLIDING_WINDOW_STATS_TOP_MACROS_SVH
`define SLIDING_WINDOW_STATS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define SWS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define SWS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/sws_pkg.sv
// Shared constants and controller/datapath interface types for the window statistics block
package sws_pkg;

   // Ring depth and derived widths
   localparam int SWS_DEPTH     = 64;
   localparam int SWS_DATA_W    = 32;
   localparam int SWS_ADDR_W    = $clog2(SWS_DEPTH);
   localparam int SWS_CNT_W     = $clog2(SWS_DEPTH + 1);
   localparam int SWS_SUM_W     = SWS_DATA_W + SWS_ADDR_W;
   localparam int SWS_DIV_CNT_W = $clog2(SWS_SUM_W + 1);

   // Fixed port widths
   localparam int SWS_LEN_W     = 7;
   localparam int SWS_HELD_W    = 7;

   // Controller -> datapath commands
   typedef struct packed {
      logic accept;     // request taken this cycle
      logic read_old;   // read the slot about to be overwritten
      logic update;     // write ring, update sum, start divider and scan
      logic scan_run;   // step the min/max scan
      logic load_out;   // load the response register
   } sws_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic len_zero;   // window disabled
      logic scan_done;  // min/max scan finished
      logic div_done;   // divider finished
      logic out_free;   // response register can take a new result
   } sws_status_type;

endpackage

### hw/rtl/sliding_window_stats_top.sv
// Top level of the sliding window average/min/max block
//
//   channel | direction | handshake                  | payload
//   req     | in        | req_valid / req_ready      | req_sample
//   rsp     | out       | rsp_valid / rsp_ready      | average, minimum, maximum, held_count
//   csr     | in        | csr_write_enable (no wait) | csr_write_data (window length)
//
// One request at a time. A request runs a ring read and a ring write, then the
// min/max scan over the ring's single read port runs alongside the 38-step serial
// divider; a disabled window goes straight to loading the response register.
// Reset is synchronous and clears the window; the ring needs no clearing pass.
// A finished result waits in the response register while the next request is taken;
// a stalled response only holds the block at its final step.
module sliding_window_stats_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sws_pkg::SWS_DATA_W-1:0]      req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sws_pkg::SWS_DATA_W-1:0]      rsp_average,
   output logic [sws_pkg::SWS_DATA_W-1:0]      rsp_minimum,
   output logic [sws_pkg::SWS_DATA_W-1:0]      rsp_maximum,
   output logic [sws_pkg::SWS_HELD_W-1:0]      rsp_held_count,
   input  logic                                csr_write_enable,
   input  logic [sws_pkg::SWS_LEN_W-1:0]       csr_write_data
);

   sws_pkg::sws_cmd_type    cmd;
   sws_pkg::sws_status_type status;

   sws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sws_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_minimum      (rsp_minimum),
      .rsp_maximum      (rsp_maximum),
      .rsp_held_count   (rsp_held_count)
   );

endmodule

### hw/rtl/sws_ram.sv
// Generic simple dual-port RAM with registered read
module sws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sws_ctrl.sv
// Sequencing state machine for the window statistics block
module sws_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sws_pkg::sws_status_type status,
   output sws_pkg::sws_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_READ_OLD = 3'd1;
   localparam logic [2:0] ST_UPDATE   = 3'd2;
   localparam logic [2:0] ST_WORK     = 3'd3;
   localparam logic [2:0] ST_FINISH   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.len_zero ? ST_FINISH : ST_READ_OLD;
            end
         end
         ST_READ_OLD: begin
            cmd.read_old = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_WORK;
         end
         ST_WORK: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done && status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/sws_datapath.sv
// Ring storage, running sum, min/max scan, serial divider and response register
module sws_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sws_pkg::sws_cmd_type                  cmd,
   output sws_pkg::sws_status_type               status,
   input  logic [sws_pkg::SWS_DATA_W-1:0]        req_sample,
   input  logic                                  csr_write_enable,
   input  logic [sws_pkg::SWS_LEN_W-1:0]         csr_write_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sws_pkg::SWS_DATA_W-1:0]        rsp_average,
   output logic [sws_pkg::SWS_DATA_W-1:0]        rsp_minimum,
   output logic [sws_pkg::SWS_DATA_W-1:0]        rsp_maximum,
   output logic [sws_pkg::SWS_HELD_W-1:0]        rsp_held_count
);

   localparam int DW  = sws_pkg::SWS_DATA_W;
   localparam int AW  = sws_pkg::SWS_ADDR_W;
   localparam int CW  = sws_pkg::SWS_CNT_W;
   localparam int SW  = sws_pkg::SWS_SUM_W;
   localparam int DCW = sws_pkg::SWS_DIV_CNT_W;
   localparam int LW  = sws_pkg::SWS_LEN_W;
   localparam int HW  = sws_pkg::SWS_HELD_W;

   // Window state
   logic [LW-1:0]        win_len_ff;
   logic [CW-1:0]        fill_ff;
   logic [AW-1:0]        wp_ff;
   logic                 full_ff;
   logic signed [SW-1:0] sum_ff;
   logic signed [SW-1:0] sum_in;
   logic [DW-1:0]        sample_ff;

   // Scan state
   logic [CW-1:0]        scan_idx_ff;
   logic                 issue_ff;
   logic                 first_ff;
   logic signed [DW-1:0] min_ff;
   logic signed [DW-1:0] max_ff;

   // Divider state
   logic [CW-1:0]        rem_ff;
   logic [SW-1:0]        quo_ff;
   logic                 neg_ff;
   logic [DCW-1:0]       div_cnt_ff;

   // Response register
   logic                 rsp_valid_ff;
   logic [DW-1:0]        rsp_average_ff;
   logic [DW-1:0]        rsp_minimum_ff;
   logic [DW-1:0]        rsp_maximum_ff;
   logic [HW-1:0]        rsp_held_count_ff;

   // Misc combinational
   logic [CW-1:0]        len_eff;
   logic                 wl_big;
   logic                 fill_lt;
   logic [CW-1:0]        wp_inc;
   logic [AW-1:0]        rd_addr;
   logic [DW-1:0]        rd_data;
   logic signed [SW-1:0] old_ext;
   logic signed [SW-1:0] new_ext;
   logic [SW-1:0]        mag_in;
   logic [CW:0]          rem_sh;
   logic                 rem_ge;
   logic [CW:0]          rem_sub;
   logic [SW-1:0]        quo_signed;
   logic signed [DW-1:0] rd_signed;

   // Effective window length, saturated to the ring depth
   always_comb begin
      wl_big  = (32'(win_len_ff) > 32'(sws_pkg::SWS_DEPTH));
      len_eff = wl_big ? CW'(sws_pkg::SWS_DEPTH) : CW'(win_len_ff);
      fill_lt = (fill_ff < len_eff);
      wp_inc  = CW'(wp_ff) + CW'(1);
   end

   // Running sum update: drop the overwritten sample when full, add the new one
   always_comb begin
      old_ext = full_ff ? SW'($signed(rd_data)) : '0;
      new_ext = SW'($signed(sample_ff));
      sum_in  = sum_ff - old_ext + new_ext;
      mag_in  = sum_in[SW-1] ? SW'(-sum_in) : SW'(sum_in);
   end

   // One restoring division step
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SW-1]};
      rem_ge  = (rem_sh >= {1'b0, fill_ff});
      rem_sub = rem_ge ? (rem_sh - {1'b0, fill_ff}) : rem_sh;
      quo_signed = neg_ff ? (~quo_ff + SW'(1)) : quo_ff;
   end

   assign rd_addr   = cmd.read_old ? wp_ff : scan_idx_ff[AW-1:0];
   assign rd_signed = $signed(rd_data);

   sws_ram #(
      .WIDTH (DW),
      .DEPTH (sws_pkg::SWS_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Window bookkeeping; a register write empties the window
   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= '0;
         fill_ff    <= '0;
         wp_ff      <= '0;
         full_ff    <= 1'b0;
         sum_ff     <= '0;
      end else if (csr_write_enable) begin
         win_len_ff <= csr_write_data;
         fill_ff    <= '0;
         wp_ff      <= '0;
         full_ff    <= 1'b0;
         sum_ff     <= '0;
      end else begin
         if (cmd.accept && (len_eff != '0)) begin
            if (fill_lt) begin
               fill_ff <= fill_ff + CW'(1);
               wp_ff   <= fill_ff[AW-1:0];
               full_ff <= 1'b0;
            end else begin
               wp_ff   <= (wp_inc >= len_eff) ? '0 : wp_inc[AW-1:0];
               full_ff <= 1'b1;
            end
         end
         if (cmd.update) begin
            sum_ff <= sum_in;
         end
      end
   end

   // Request sample holding register
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
   end

   // Min/max scan over ring entries 0..fill-1, one read per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         issue_ff    <= 1'b0;
         first_ff    <= 1'b1;
      end else if (cmd.update) begin
         scan_idx_ff <= '0;
         issue_ff    <= 1'b0;
         first_ff    <= 1'b1;
      end else begin
         issue_ff <= cmd.scan_run && (scan_idx_ff < fill_ff);
         if (cmd.scan_run && (scan_idx_ff < fill_ff)) begin
            scan_idx_ff <= scan_idx_ff + CW'(1);
         end
         if (issue_ff) begin
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         min_ff <= '0;
         max_ff <= '0;
      end else if (issue_ff) begin
         if (first_ff || (rd_signed < min_ff)) begin
            min_ff <= rd_signed;
         end
         if (first_ff || (rd_signed > max_ff)) begin
            max_ff <= rd_signed;
         end
      end
   end

   // Serial divider: magnitude of the sum by the count, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.update) begin
         div_cnt_ff <= DCW'(SW);
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         quo_ff <= mag_in;
         rem_ff <= '0;
         neg_ff <= sum_in[SW-1];
      end else if (div_cnt_ff != '0) begin
         quo_ff <= {quo_ff[SW-2:0], rem_ge};
         rem_ff <= rem_sub[CW-1:0];
      end
   end

   // Response register; a new result may load as the old one is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_average_ff    <= (fill_ff == '0) ? '0 : quo_signed[DW-1:0];
         rsp_minimum_ff    <= min_ff;
         rsp_maximum_ff    <= max_ff;
         rsp_held_count_ff <= HW'(fill_ff);
      end
   end

   // Status back to the controller
   always_comb begin
      status.len_zero  = (len_eff == '0);
      status.scan_done = (scan_idx_ff == fill_ff) && !issue_ff;
      status.div_done  = (div_cnt_ff == '0);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = rsp_average_ff;
   assign rsp_minimum    = rsp_minimum_ff;
   assign rsp_maximum    = rsp_maximum_ff;
   assign rsp_held_count = rsp_held_count_ff;

endmodule

### hw/rtl/sws_checker.sv
// Port-level assertion checker for the window statistics block, with its bind
`include "sliding_window_stats_top_macros.svh"

module sws_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sws_pkg::SWS_DATA_W-1:0] rsp_average,
   input logic [sws_pkg::SWS_DATA_W-1:0] rsp_minimum,
   input logic [sws_pkg::SWS_DATA_W-1:0] rsp_maximum,
   input logic [sws_pkg::SWS_HELD_W-1:0] rsp_held_count
);

   // Held count never exceeds the ring depth
   `SWS_ASSERT_NOW(a_held_range, rsp_valid, 32'(rsp_held_count) <= 32'(sws_pkg::SWS_DEPTH), "held_count above ring depth")

   // An empty window reports all zeros
   `SWS_ASSERT_NOW(a_empty_zero, rsp_valid && (rsp_held_count == '0), (rsp_average == '0) && (rsp_minimum == '0) && (rsp_maximum == '0), "empty window result not zero")

   // Average lies between minimum and maximum
   `SWS_ASSERT_NOW(a_avg_bounds, rsp_valid && (rsp_held_count != '0), ($signed(rsp_minimum) <= $signed(rsp_average)) && ($signed(rsp_average) <= $signed(rsp_maximum)), "average outside min/max")

   // A taken request keeps the block busy in the next cycle
   `SWS_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken on back-to-back cycles")

   // A stalled response holds its valid, average and held count
   `SWS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_average) && $stable(rsp_held_count), "stalled response changed")

endmodule

bind sliding_window_stats_top sws_checker u_sws_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_average    (rsp_average),
   .rsp_minimum    (rsp_minimum),
   .rsp_maximum    (rsp_maximum),
   .rsp_held_count (rsp_held_count)
);

### tb/sv/sliding_window_stats_top_test.sv
// Self-checking testbench for the sliding window average/min/max block
`timescale 1ns / 1ps

module sliding_window_stats_top_test;

   localparam int DW    = sws_pkg::SWS_DATA_W;
   localparam int HW    = sws_pkg::SWS_HELD_W;
   localparam int LW    = sws_pkg::SWS_LEN_W;
   localparam int DEPTH = sws_pkg::SWS_DEPTH;

   typedef struct {
      logic signed [DW-1:0] average;
      logic signed [DW-1:0] minimum;
      logic signed [DW-1:0] maximum;
      logic [HW-1:0]        held_count;
   } window_stats_type;

   localparam int HOLD_CYCLES = 400;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [DW-1:0]           req_sample = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [DW-1:0]           rsp_average;
   logic [DW-1:0]           rsp_minimum;
   logic [DW-1:0]           rsp_maximum;
   logic [HW-1:0]           rsp_held_count;
   logic                    csr_write_enable = 1'b0;
   logic [LW-1:0]           csr_write_data = '0;

   // Samples waiting to be sent and statistics waiting to come back
   logic [DW-1:0]           sample_backlog[$];
   window_stats_type        pending_stats[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;

   // Long receiver hold-off
   logic hold_go    = 1'b0;
   logic hold_fired = 1'b0;
   int   hold_left  = 0;

   // Shadow copy of the window
   logic signed [DW-1:0]         window_ring[DEPTH];
   int unsigned                  window_len  = 0;
   int unsigned                  held        = 0;
   int unsigned                  newest      = 0;
   longint                       window_sum  = 0;

   sliding_window_stats_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_minimum      (rsp_minimum),
      .rsp_maximum      (rsp_maximum),
      .rsp_held_count   (rsp_held_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Push one sample into the shadow window and return the new statistics
   function automatic window_stats_type compute_window_stats(logic signed [DW-1:0] sample);
      int unsigned      span;
      int unsigned      slot;
      longint           lo;
      longint           hi;
      window_stats_type stats;
      span = (window_len > DEPTH) ? DEPTH : window_len;
      lo = 0;
      hi = 0;
      if (span != 0) begin
         if (held < span) begin
            held++;
            newest = held - 1;
         end else begin
            slot = newest + 1;
            if (slot >= span) slot = 0;
            newest = slot;
            window_sum -= longint'(window_ring[newest]);
         end
         window_ring[newest] = sample;
         window_sum += longint'(sample);
      end
      stats.average = '0;
      if (held != 0) begin
         lo = window_ring[0];
         hi = lo;
         for (int i = 1; i < held; i++) begin
            if (window_ring[i] < lo) lo = window_ring[i];
            if (window_ring[i] > hi) hi = window_ring[i];
         end
         // signed longint division truncates toward zero
         stats.average = DW'(window_sum / longint'(held));
      end
      stats.minimum    = DW'(lo);
      stats.maximum    = DW'(hi);
      stats.held_count = HW'(held);
      return stats;
   endfunction

   task automatic report_mismatch(string what, logic [DW-1:0] want,
                                  logic [DW-1:0] got);
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
      error_count++;
   endtask

   // Driver: predict on each accepted request, then offer the next sample
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            pending_stats.push_back(compute_window_stats(req_sample));
         if (!req_valid || req_ready) begin
            if (sample_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid  <= 1'b1;
               req_sample <= sample_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response with the oldest prediction
   always @(posedge clock) begin : monitor
      window_stats_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            report_mismatch("unexpected response (average)", '0, rsp_average);
         end else begin
            want = pending_stats.pop_front();
            if (rsp_average !== want.average)
               report_mismatch("average", want.average, rsp_average);
            if (rsp_minimum !== want.minimum)
               report_mismatch("minimum", want.minimum, rsp_minimum);
            if (rsp_maximum !== want.maximum)
               report_mismatch("maximum", want.maximum, rsp_maximum);
            if (rsp_held_count !== want.held_count)
               report_mismatch("held_count", DW'(want.held_count),
                               DW'(rsp_held_count));
         end
      end
      rsp_ready <= !reset && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
   end

   // One long receiver hold-off, fired on request
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_fired <= 1'b0;
      end else if (hold_go && !hold_fired) begin
         hold_left  <= HOLD_CYCLES;
         hold_fired <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Register write while idle; the shadow window empties with it
   task automatic set_window(int len);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= LW'(len);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_len = len;
      held       = 0;
      newest     = 0;
      window_sum = 0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_valid || pending_stats.size() != 0);
   endtask

   function automatic logic [DW-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return DW'($urandom_range(512) - 256);
         3:       return DW'($urandom_range(2) - 1);
         default: return $urandom();
      endcase
   endfunction

   // Random samples, now and then a run of one extreme to stress the sum
   task automatic queue_random(int count);
      logic [DW-1:0] extreme;
      int            run;
      int            n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(39) == 0) begin
            extreme = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            run = $urandom_range(80, 10);
            repeat (run) sample_backlog.push_back(extreme);
            n += run;
         end else begin
            sample_backlog.push_back(pick_sample());
            n++;
         end
      end
   endtask

   task automatic run_phase(int len, int idle, int stall, int count, bit pressure);
      set_window(len);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      if (pressure) hold_go = 1'b1;
      queue_random(count);
      wait_drained();
   endtask

   // Stimulus
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // disabled window ignores samples and reports zeros
      set_window(0);
      sample_backlog = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
      wait_drained();

      // single-entry window
      set_window(1);
      sample_backlog = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
      wait_drained();

      // small window: wraparound and truncation of negative averages
      set_window(3);
      sample_backlog = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFD,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
      wait_drained();

      // oversized length saturates to the ring depth
      set_window(100);
      sample_backlog = '{32'h8000_0000, 32'h0000_0005, 32'hFFFF_FFF9};
      wait_drained();

      // random phases across window lengths and idling patterns
      run_phase(64,  0,  0,  260, 1'b0);
      run_phase(5,   50, 0,  180, 1'b0);
      run_phase(127, 0,  50, 220, 1'b0);
      run_phase(2,   22, 22, 160, 1'b0);
      run_phase(64,  22, 22, 260, 1'b0);
      run_phase(17,  0,  0,  150, 1'b1);
      run_phase(65,  50, 0,  150, 1'b0);
      run_phase(0,   0,  50, 30,  1'b0);
      run_phase(1,   22, 22, 100, 1'b0);
      run_phase(40,  0,  0,  170, 1'b0);

      // let any stray response show up
      repeat (150) @(negedge clock);
      if (pending_stats.size() != 0)
         report_mismatch("responses never returned", pending_stats.size(), 0);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Timeout
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### sliding_window_stats_top.f
+incdir+hw/rtl
hw/rtl/sws_pkg.sv
hw/rtl/sws_ram.sv
hw/rtl/sws_ctrl.sv
hw/rtl/sws_datapath.sv
hw/rtl/sliding_window_stats_top.sv
hw/rtl/sws_checker.sv
tb/sv/sliding_window_stats_top_test.sv
